// File: rtl/core/pse_pkg.sv
`default_nettype none

package pse_pkg;

  // Sizing of the sieve
  localparam int unsigned MaxLimit = 256;
  localparam int unsigned LimitW   = 9;
  localparam int unsigned AddrW    = 9;
  localparam int unsigned MultW    = LimitW + 1;
  localparam int unsigned MemDepth = MaxLimit + 1;

  localparam logic [LimitW-1:0] MaxLimitV = LimitW'(MaxLimit);
  localparam logic [LimitW-1:0] FirstCand = LimitW'(2);

  // One access to the composite mark memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic             wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mark_req_t;

endpackage

`default_nettype wire

// File: rtl/core/pse_mark_ram.sv
`default_nettype none

module pse_mark_ram (
  input  wire logic               clk_i,
  input  wire pse_pkg::mark_req_t req_i,
  output logic                    rdata_o
);

  logic mem_q [pse_pkg::MemDepth];
  logic rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      if (req_i.we && (req_i.waddr == req_i.raddr)) begin
        rdata_q <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/prime_sieve_enumerator_unit.sv
// One request at a time; in_stall_o is high from acceptance until the last result is loaded.
// Per request with limit n >= 2 the unit clears the mark memory for 2..n, checks each candidate
// 2..n in turn, marks every multiple of each prime found, and then flushes the last prime.
// First result (2) leaves once 3 is found, or at the flush when n = 2.
// Limit below 2: one result, loaded from StNone once the output register is free.
// Reset (rst_ni, asynchronous) clears the control; the mark memory is cleared per request.
`default_nettype none

module prime_sieve_enumerator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [pse_pkg::LimitW-1:0] limit_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [pse_pkg::LimitW-1:0]      prime_o,
  output logic                            last_o,
  output logic                            none_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StMark  = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;
  localparam logic [2:0] StNone  = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [pse_pkg::LimitW-1:0]   lim_q, lim_d;
  logic [pse_pkg::LimitW-1:0]   cand_q, cand_d;
  logic [pse_pkg::MultW-1:0]    mult_q, mult_d;
  logic [pse_pkg::LimitW-1:0]   pend_q, pend_d;
  logic                         pend_v_q, pend_v_d;

  logic                         out_valid_q;
  logic [pse_pkg::LimitW-1:0]   prime_q;
  logic                         last_q, none_q;

  pse_pkg::mark_req_t           req;
  logic                         marked;

  logic                         out_free, load;
  logic [pse_pkg::LimitW-1:0]   ld_prime;
  logic                         ld_last, ld_none;
  logic                         adv;
  logic [pse_pkg::LimitW-1:0]   lim_sat;
  logic [pse_pkg::MultW-1:0]    cand_inc, cand_dbl, mult_sum, lim_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign lim_sat  = (limit_i > pse_pkg::MaxLimitV) ? pse_pkg::MaxLimitV : limit_i;
  assign lim_ext  = {1'b0, lim_q};
  assign cand_inc = {1'b0, cand_q} + pse_pkg::MultW'(1);
  assign cand_dbl = {cand_q, 1'b0};
  assign mult_sum = mult_q + {1'b0, cand_q};

  // Sieve sequencer
  always_comb begin
    state_d  = state_q;
    lim_d    = lim_q;
    cand_d   = cand_q;
    mult_d   = mult_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    req      = '0;
    load     = 1'b0;
    ld_prime = pend_q;
    ld_last  = 1'b0;
    ld_none  = 1'b0;
    adv      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          lim_d    = lim_sat;
          cand_d   = pse_pkg::FirstCand;
          pend_v_d = 1'b0;
          if (lim_sat < pse_pkg::FirstCand) begin
            state_d = StNone;
          end else begin
            state_d = StClear;
          end
        end
      end
      StClear: begin
        req.we    = 1'b1;
        req.waddr = cand_q;
        req.wdata = 1'b0;
        if (cand_q == lim_q) begin
          cand_d    = pse_pkg::FirstCand;
          req.re    = 1'b1;
          req.raddr = pse_pkg::FirstCand;
          state_d   = StCheck;
        end else begin
          cand_d = cand_inc[pse_pkg::LimitW-1:0];
        end
      end
      StCheck: begin
        if (marked) begin
          adv = 1'b1;
        end else if (!pend_v_q || out_free) begin
          // new prime: release the previous one, hold this one back
          load     = pend_v_q;
          pend_d   = cand_q;
          pend_v_d = 1'b1;
          if (cand_dbl > lim_ext) begin
            adv = 1'b1;
          end else begin
            mult_d  = cand_dbl;
            state_d = StMark;
          end
        end
      end
      StMark: begin
        req.we    = 1'b1;
        req.waddr = mult_q[pse_pkg::AddrW-1:0];
        req.wdata = 1'b1;
        if (mult_sum > lim_ext) begin
          adv = 1'b1;
        end else begin
          mult_d = mult_sum;
        end
      end
      StFlush: begin
        if (out_free) begin
          load    = 1'b1;
          ld_last = 1'b1;
          state_d = StIdle;
        end
      end
      StNone: begin
        if (out_free) begin
          load     = 1'b1;
          ld_prime = '0;
          ld_last  = 1'b1;
          ld_none  = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Step to the next candidate and read its mark, or flush after the last candidate
    if (adv) begin
      if (cand_inc > lim_ext) begin
        state_d = StFlush;
      end else begin
        cand_d    = cand_inc[pse_pkg::LimitW-1:0];
        req.re    = 1'b1;
        req.raddr = cand_inc[pse_pkg::AddrW-1:0];
        state_d   = StCheck;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cand_q   <= pse_pkg::FirstCand;
      mult_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cand_q   <= cand_d;
      mult_q   <= mult_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_d;
    pend_q <= pend_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prime_q <= ld_prime;
      last_q  <= ld_last;
      none_q  <= ld_none;
    end
  end

  pse_mark_ram u_mark_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (marked)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;
  assign last_o      = last_q;
  assign none_o      = none_q;

endmodule

`default_nettype wire

// File: rtl/core/pse_checker.sv
`default_nettype none

module pse_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [pse_pkg::LimitW-1:0] prime_o,
  input wire logic                       last_o,
  input wire logic                       none_o
);

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(prime_o) && $stable(last_o)
      && $stable(none_o))
    else $error("stalled result changed");

  // The empty-range result is zero and closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_o |-> (prime_o == '0) && last_o)
    else $error("none result malformed");

  // Every real result is a number of at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !none_o |-> (prime_o >= pse_pkg::FirstCand))
    else $error("prime below two");

  // An accepted request keeps the input side busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not busy after acceptance");

endmodule

bind prime_sieve_enumerator_unit pse_checker u_pse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .prime_o     (prime_o),
  .last_o      (last_o),
  .none_o      (none_o)
);

`default_nettype wire
